>>> rtl/core/ccpd_pkg.sv
// Shared types and codes for the caption change point detector.
package ccpd_pkg;

  // Width of a hash bit distance and of the change threshold register.
  localparam int THR_W = 7;

  // Configuration register indexes.
  localparam logic [2:0] REG_PRESENT_LEVEL      = 3'd0;
  localparam logic [2:0] REG_SETTLE_FRAMES      = 3'd1;
  localparam logic [2:0] REG_SAME_DIST_MAX      = 3'd2;
  localparam logic [2:0] REG_VERIFY_ENABLE      = 3'd3;
  localparam logic [2:0] REG_VERIFY_THRESHOLD   = 3'd4;
  localparam logic [2:0] REG_PATROL_ENABLE      = 3'd5;
  localparam logic [2:0] REG_PATROL_THRESHOLD   = 3'd6;
  localparam logic [2:0] REG_PATROL_INTERVAL    = 3'd7;

  // Event kinds.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_IN     = 2'd1;
  localparam logic [1:0] EV_OUT    = 2'd2;
  localparam logic [1:0] EV_CHANGE = 2'd3;

  typedef struct packed {
    logic [15:0]        present_level;
    logic [7:0]         settle_frames;
    logic [THR_W-1:0]   same_dist_max;
    logic               verify_enable;
    logic signed [15:0] verify_threshold;
    logic               patrol_enable;
    logic signed [15:0] patrol_threshold;
    logic [15:0]        patrol_interval;
  } cfg_t;

  typedef struct packed {
    logic same_anchor;
    logic same_prev;
  } hash_match_t;

endpackage

>>> rtl/core/caption_change_point_detector.sv
// Caption change point detector: one frame record in, one event record out, one per clock
// while out_ready keeps up. Each frame request is captured in an input register, decided
// against the tracking state by combinational logic (two 64-bit hash popcounts, threshold
// compares and the mode update), and the result lands in an output register, so a request
// passes the input and then the output register; the state update loop in the tracker
// closes through its state registers. While a result waits on out_ready, one more request
// can still be taken into the input register. Configuration writes are always taken
// (cfg_ready is tied high) and belong in idle periods.
module caption_change_point_detector import ccpd_pkg::*; #(
  parameter int HASH_BITS = 64,
  parameter int TIME_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          fg_ratio,
  input  logic [TIME_BITS-1:0] frame_ms,
  input  logic [HASH_BITS-1:0] frame_hash,
  input  logic                 crop_present,
  input  logic signed [15:0]   sim_full,
  input  logic signed [15:0]   sim_foreground,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           event_kind,
  output logic [TIME_BITS-1:0] event_ms,
  output logic                 capture_anchor
);

  cfg_t                 cfg;
  hash_match_t          match;
  logic                 item_valid;
  logic [15:0]          item_fg_ratio;
  logic [TIME_BITS-1:0] item_frame_ms;
  logic [HASH_BITS-1:0] item_frame_hash;
  logic                 item_crop_present;
  logic signed [15:0]   item_sim_full;
  logic signed [15:0]   item_sim_foreground;
  logic [HASH_BITS-1:0] anchor_hash;
  logic [HASH_BITS-1:0] prev_hash;
  logic [1:0]           dec_kind;
  logic [TIME_BITS-1:0] dec_ms;
  logic                 dec_capture;
  logic                 advance;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || advance;

  ccpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_fg_ratio       <= fg_ratio;
      item_frame_ms       <= frame_ms;
      item_frame_hash     <= frame_hash;
      item_crop_present   <= crop_present;
      item_sim_full       <= sim_full;
      item_sim_foreground <= sim_foreground;
    end
  end

  ccpd_hash_cmp #(.HASH_BITS(HASH_BITS)) u_hash_cmp (
    .frame_hash  (item_frame_hash),
    .anchor_hash (anchor_hash),
    .prev_hash   (prev_hash),
    .dist_max    (cfg.same_dist_max),
    .match       (match)
  );

  ccpd_tracker #(.HASH_BITS(HASH_BITS), .TIME_BITS(TIME_BITS)) u_tracker (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .cfg            (cfg),
    .fg_ratio       (item_fg_ratio),
    .frame_ms       (item_frame_ms),
    .frame_hash     (item_frame_hash),
    .crop_present   (item_crop_present),
    .sim_full       (item_sim_full),
    .sim_foreground (item_sim_foreground),
    .match          (match),
    .anchor_hash    (anchor_hash),
    .prev_hash      (prev_hash),
    .event_kind     (dec_kind),
    .event_ms       (dec_ms),
    .capture_anchor (dec_capture)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_kind     <= dec_kind;
      event_ms       <= dec_ms;
      capture_anchor <= dec_capture;
    end
  end

endmodule

>>> rtl/core/ccpd_cfg_regs.sv
// Configuration register file of the caption change point detector.
module ccpd_cfg_regs import ccpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.present_level      <= '0;
      cfg.settle_frames      <= 8'd1;
      cfg.same_dist_max      <= '0;
      cfg.verify_enable      <= 1'b0;
      cfg.verify_threshold   <= '0;
      cfg.patrol_enable      <= 1'b0;
      cfg.patrol_threshold   <= '0;
      cfg.patrol_interval    <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PRESENT_LEVEL:      cfg.present_level      <= wr_data;
        REG_SETTLE_FRAMES:      cfg.settle_frames      <= wr_data[7:0];
        REG_SAME_DIST_MAX:      cfg.same_dist_max      <= wr_data[THR_W-1:0];
        REG_VERIFY_ENABLE:      cfg.verify_enable      <= wr_data[0];
        REG_VERIFY_THRESHOLD:   cfg.verify_threshold   <= wr_data;
        REG_PATROL_ENABLE:      cfg.patrol_enable      <= wr_data[0];
        REG_PATROL_THRESHOLD:   cfg.patrol_threshold   <= wr_data;
        REG_PATROL_INTERVAL:    cfg.patrol_interval    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/ccpd_hash_cmp.sv
// Hash bit distances against the anchor and previous hashes, compared to the threshold.
module ccpd_hash_cmp import ccpd_pkg::*; #(
  parameter int HASH_BITS = 64
) (
  input  logic [HASH_BITS-1:0] frame_hash,
  input  logic [HASH_BITS-1:0] anchor_hash,
  input  logic [HASH_BITS-1:0] prev_hash,
  input  logic [THR_W-1:0]     dist_max,
  output hash_match_t          match
);

  localparam int NCHUNK = (HASH_BITS + 7) / 8;
  localparam int PAD_W  = NCHUNK * 8;

  logic [PAD_W-1:0] diff_anchor;
  logic [PAD_W-1:0] diff_prev;
  logic [3:0]       cnt_anchor [NCHUNK];
  logic [3:0]       cnt_prev   [NCHUNK];
  logic [THR_W-1:0] dist_anchor;
  logic [THR_W-1:0] dist_prev;

  assign diff_anchor = PAD_W'(frame_hash ^ anchor_hash);
  assign diff_prev   = PAD_W'(frame_hash ^ prev_hash);

  // Count per byte, then add the byte counts.
  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      cnt_anchor[c] = '0;
      cnt_prev[c]   = '0;
      for (int b = 0; b < 8; b++) begin
        cnt_anchor[c] = cnt_anchor[c] + 4'(diff_anchor[c*8 + b]);
        cnt_prev[c]   = cnt_prev[c]   + 4'(diff_prev[c*8 + b]);
      end
    end
    dist_anchor = '0;
    dist_prev   = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      dist_anchor = dist_anchor + THR_W'(cnt_anchor[c]);
      dist_prev   = dist_prev   + THR_W'(cnt_prev[c]);
    end
  end

  assign match.same_anchor = (dist_anchor <= dist_max);
  assign match.same_prev   = (dist_prev   <= dist_max);

endmodule

>>> rtl/core/ccpd_tracker.sv
// Presence hysteresis, change candidate and patrol state, with the per-frame decision.
module ccpd_tracker import ccpd_pkg::*; #(
  parameter int HASH_BITS = 64,
  parameter int TIME_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  cfg_t                 cfg,
  input  logic [15:0]          fg_ratio,
  input  logic [TIME_BITS-1:0] frame_ms,
  input  logic [HASH_BITS-1:0] frame_hash,
  input  logic                 crop_present,
  input  logic signed [15:0]   sim_full,
  input  logic signed [15:0]   sim_foreground,
  input  hash_match_t          match,
  output logic [HASH_BITS-1:0] anchor_hash,
  output logic [HASH_BITS-1:0] prev_hash,
  output logic [1:0]           event_kind,
  output logic [TIME_BITS-1:0] event_ms,
  output logic                 capture_anchor
);

  localparam logic [1:0] MODE_EMPTY        = 2'd0;
  localparam logic [1:0] MODE_STABLE       = 2'd1;
  localparam logic [1:0] MODE_STABLE_PRIME = 2'd2;

  logic [1:0]           mode, mode_next;
  logic [HASH_BITS-1:0] anchor_hash_next;
  logic                 anchor_ok, anchor_ok_next;
  logic                 prev_ok;
  logic [7:0]           present_run, present_run_next;
  logic [7:0]           absent_run, absent_run_next;
  logic [15:0]          patrol_run, patrol_run_next;
  logic                 fp_held, fp_held_next;
  logic                 fa_held, fa_held_next;
  logic                 cand_held, cand_held_next;
  logic [TIME_BITS-1:0] fp_ms, fp_ms_next;
  logic [TIME_BITS-1:0] fa_ms, fa_ms_next;
  logic [TIME_BITS-1:0] cand_ms, cand_ms_next;

  logic        present;
  logic        sims_ok;
  logic        settled;
  logic [7:0]  present_inc;
  logic [7:0]  absent_inc;
  logic [15:0] patrol_inc;

  assign present     = (fg_ratio >= cfg.present_level);
  assign sims_ok     = anchor_ok && crop_present;
  assign settled     = prev_ok && match.same_prev;
  assign present_inc = (&present_run) ? present_run : present_run + 8'd1;
  assign absent_inc  = (&absent_run)  ? absent_run  : absent_run + 8'd1;
  assign patrol_inc  = (&patrol_run)  ? patrol_run  : patrol_run + 16'd1;

  always_comb begin
    mode_next        = mode;
    anchor_hash_next = anchor_hash;
    anchor_ok_next   = anchor_ok;
    present_run_next = present_run;
    absent_run_next  = absent_run;
    patrol_run_next  = patrol_run;
    fp_held_next     = fp_held;
    fa_held_next     = fa_held;
    cand_held_next   = cand_held;
    fp_ms_next       = fp_ms;
    fa_ms_next       = fa_ms;
    cand_ms_next     = cand_ms;
    event_kind       = EV_NONE;
    event_ms         = '0;
    capture_anchor   = 1'b0;

    if (mode == MODE_EMPTY) begin
      if (present) begin
        if (present_run == 8'd0) begin
          fp_ms_next   = frame_ms;
          fp_held_next = 1'b1;
        end
        present_run_next = present_inc;
        absent_run_next  = '0;
        if (present_inc >= cfg.settle_frames) begin
          // A zero remembered time falls back to the current frame time.
          event_ms = (fp_held_next && fp_ms_next != '0) ? fp_ms_next : frame_ms;
          event_kind       = EV_IN;
          capture_anchor   = 1'b1;
          mode_next        = MODE_STABLE;
          anchor_hash_next = frame_hash;
          anchor_ok_next   = crop_present;
          present_run_next = '0;
          fp_held_next     = 1'b0;
          fp_ms_next       = '0;
        end
      end else begin
        present_run_next = '0;
        fp_held_next     = 1'b0;
        fp_ms_next       = '0;
      end
    end else if (!present) begin
      if (absent_run == 8'd0) begin
        fa_ms_next   = frame_ms;
        fa_held_next = 1'b1;
      end
      absent_run_next = absent_inc;
      if (absent_inc >= cfg.settle_frames) begin
        event_ms = (fa_held_next && fa_ms_next != '0) ? fa_ms_next : frame_ms;
        event_kind       = EV_OUT;
        mode_next        = MODE_EMPTY;
        absent_run_next  = '0;
        fa_held_next     = 1'b0;
        fa_ms_next       = '0;
        cand_held_next   = 1'b0;
        cand_ms_next     = '0;
        anchor_hash_next = '0;
        anchor_ok_next   = 1'b0;
      end
    end else begin
      absent_run_next = '0;
      fa_held_next    = 1'b0;
      fa_ms_next      = '0;
      if (match.same_anchor) begin
        patrol_run_next = patrol_inc;
        if (cfg.patrol_enable && cand_held && settled) begin
          event_kind      = EV_CHANGE;
          event_ms        = cand_ms;
          patrol_run_next = '0;
        end else if (cfg.patrol_enable && patrol_inc >= cfg.patrol_interval && sims_ok) begin
          patrol_run_next = '0;
          if (sim_foreground < cfg.patrol_threshold && !cand_held) begin
            cand_held_next = 1'b1;
            cand_ms_next   = frame_ms;
          end
        end
      end else if (cfg.verify_enable && sims_ok && sim_full > cfg.verify_threshold) begin
        // Similarity vetoes the hash change: drop the candidate.
        cand_held_next = 1'b0;
        cand_ms_next   = '0;
      end else begin
        if (!cand_held) begin
          cand_held_next = 1'b1;
          cand_ms_next   = frame_ms;
        end
        if (settled) begin
          event_kind = EV_CHANGE;
          event_ms   = cand_ms_next;
        end
      end
      if (event_kind == EV_CHANGE) begin
        capture_anchor   = 1'b1;
        cand_held_next   = 1'b0;
        cand_ms_next     = '0;
        mode_next        = MODE_STABLE_PRIME;
        anchor_hash_next = frame_hash;
        anchor_ok_next   = crop_present;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_EMPTY;
      anchor_hash <= '0;
      anchor_ok   <= 1'b0;
      prev_hash   <= '0;
      prev_ok     <= 1'b0;
      present_run <= '0;
      absent_run  <= '0;
      patrol_run  <= '0;
      fp_held     <= 1'b0;
      fa_held     <= 1'b0;
      cand_held   <= 1'b0;
      fp_ms       <= '0;
      fa_ms       <= '0;
      cand_ms     <= '0;
    end else if (step) begin
      mode        <= mode_next;
      anchor_hash <= anchor_hash_next;
      anchor_ok   <= anchor_ok_next;
      prev_hash   <= frame_hash;
      prev_ok     <= 1'b1;
      present_run <= present_run_next;
      absent_run  <= absent_run_next;
      patrol_run  <= patrol_run_next;
      fp_held     <= fp_held_next;
      fa_held     <= fa_held_next;
      cand_held   <= cand_held_next;
      fp_ms       <= fp_ms_next;
      fa_ms       <= fa_ms_next;
      cand_ms     <= cand_ms_next;
    end
  end

endmodule

>>> rtl/core/ccpd_checker.sv
// Port-level checks for the caption change point detector, bound to the top level.
module ccpd_checker import ccpd_pkg::*; #(
  parameter int TIME_BITS = 40
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           event_kind,
  input logic [TIME_BITS-1:0] event_ms,
  input logic                 capture_anchor
);

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_none_zero_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_NONE |-> event_ms == '0)
    else $error("no-event result carries a nonzero time");

  a_capture_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> capture_anchor == (event_kind == EV_IN || event_kind == EV_CHANGE))
    else $error("anchor capture does not match the event kind");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(event_ms)
      && $stable(capture_anchor))
    else $error("stalled result changed");

endmodule

bind caption_change_point_detector ccpd_checker #(.TIME_BITS(TIME_BITS)) u_ccpd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_kind     (event_kind),
  .event_ms       (event_ms),
  .capture_anchor (capture_anchor)
);
